>>> hdl/tilt_compensated_compass_heading_defines.svh
// assertion macros shared by the checker
`ifndef TILT_COMPENSATED_COMPASS_HEADING_DEFINES_SVH
`define TILT_COMPENSATED_COMPASS_HEADING_DEFINES_SVH

// checked only while out of reset
`define TCCH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tcch assertion failed");

// checked on every edge, reset included
`define TCCH_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("tcch assertion failed");

`endif

>>> hdl/tcch_pkg.sv
package tcch_pkg;

    localparam int ZW = 24;
    localparam int CSW = 19;
    localparam int VW = 56;

    localparam logic signed [ZW-1:0] PI_F20      = 24'sd3294199;
    localparam logic signed [ZW-1:0] HALF_PI_F20 = 24'sd1647099;
    localparam logic signed [CSW-1:0] GAIN_F16   = 19'sd39797;
    localparam logic signed [19:0] PI_Q13        = 20'sd25736;
    localparam logic signed [19:0] TWO_PI_Q13    = 20'sd51472;
    localparam logic [15:0] DEG_MUL              = 16'd58671;
    localparam logic [16:0] DEG_MAX              = 17'd46079;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_mag;

    function automatic logic signed [ZW-1:0] atan_f20(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 24'sd823550;
            1:  v = 24'sd486170;
            2:  v = 24'sd256879;
            3:  v = 24'sd130396;
            4:  v = 24'sd65451;
            5:  v = 24'sd32757;
            6:  v = 24'sd16383;
            7:  v = 24'sd8192;
            8:  v = 24'sd4096;
            9:  v = 24'sd2048;
            10: v = 24'sd1024;
            11: v = 24'sd512;
            12: v = 24'sd256;
            13: v = 24'sd128;
            14: v = 24'sd64;
            15: v = 24'sd32;
            16: v = 24'sd16;
            17: v = 24'sd8;
            18: v = 24'sd4;
            19: v = 24'sd2;
            20: v = 24'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/tcch_sincos.sv
module tcch_sincos #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [tcch_pkg::ZW-1:0]      i_z,
    output logic signed [tcch_pkg::CSW-1:0]     o_cos,
    output logic signed [tcch_pkg::CSW-1:0]     o_sin
);

    logic signed [tcch_pkg::CSW-1:0] r_x [CORDIC_STEPS+1];
    logic signed [tcch_pkg::CSW-1:0] r_y [CORDIC_STEPS+1];
    logic signed [tcch_pkg::ZW-1:0]  r_z [CORDIC_STEPS+1];

    always_comb begin
        r_x[0] = tcch_pkg::GAIN_F16;
        r_y[0] = '0;
        r_z[0] = i_z;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic signed [tcch_pkg::ZW-1:0] A = tcch_pkg::atan_f20(i);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - A;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + A;
                end
            end
        end
    end

    assign o_cos = r_x[CORDIC_STEPS];
    assign o_sin = r_y[CORDIC_STEPS];

endmodule

>>> hdl/tcch_vector.sv
module tcch_vector #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [tcch_pkg::VW-1:0]    i_x,
    input  logic signed [tcch_pkg::VW-1:0]    i_y,
    input  logic signed [tcch_pkg::ZW-1:0]    i_z,
    output logic signed [tcch_pkg::ZW-1:0]    o_z
);

    logic signed [tcch_pkg::VW-1:0] r_x [CORDIC_STEPS+1];
    logic signed [tcch_pkg::VW-1:0] r_y [CORDIC_STEPS+1];
    logic signed [tcch_pkg::ZW-1:0] r_z [CORDIC_STEPS+1];

    always_comb begin
        r_x[0] = i_x;
        r_y[0] = i_y;
        r_z[0] = i_z;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic signed [tcch_pkg::ZW-1:0] A = tcch_pkg::atan_f20(i);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + A;
                end else if (r_y[i] < 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - A;
                end else begin
                    r_x[i+1] <= r_x[i];
                    r_y[i+1] <= r_y[i];
                    r_z[i+1] <= r_z[i];
                end
            end
        end
    end

    assign o_z = r_z[CORDIC_STEPS];

endmodule

>>> hdl/tilt_compensated_compass_heading.sv
// pipeline: one register stage per cordic step in the sin/cos and atan2 units
// throughput: one request per cycle; the whole pipeline holds while a result waits
// reset: synchronous active-low clears the valid bits and unit select (radians)
module tilt_compensated_compass_heading #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,   // mag_x, mag_y, mag_z, pitch_angle, roll_angle
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // heading
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    localparam int N = CORDIC_STEPS;
    localparam int LAT = 2 * N + 7;

    logic           en;
    logic [LAT-1:0] r_vld;
    logic           r_unit;

    assign en = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_unit <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
            end
            if (i_cfg_we) begin
                r_unit <= i_cfg_wdata;
            end
        end
    end

    // angle fold into +-pi/2
    logic signed [16:0] theta;
    logic signed [23:0] zt_raw, zp_raw, n_zt, n_zp;
    logic               n_negt, n_negp;

    assign theta  = -$signed({i_s_tdata[63], i_s_tdata[63:48]});
    assign zt_raw = {theta, 7'b0};
    assign zp_raw = {i_s_tdata[79], i_s_tdata[79:64], 7'b0};

    always_comb begin
        n_zt = zt_raw;
        n_negt = 1'b0;
        if (zt_raw > tcch_pkg::HALF_PI_F20) begin
            n_zt = zt_raw - tcch_pkg::PI_F20;
            n_negt = 1'b1;
        end else if (zt_raw < -tcch_pkg::HALF_PI_F20) begin
            n_zt = zt_raw + tcch_pkg::PI_F20;
            n_negt = 1'b1;
        end
        n_zp = zp_raw;
        n_negp = 1'b0;
        if (zp_raw > tcch_pkg::HALF_PI_F20) begin
            n_zp = zp_raw - tcch_pkg::PI_F20;
            n_negp = 1'b1;
        end else if (zp_raw < -tcch_pkg::HALF_PI_F20) begin
            n_zp = zp_raw + tcch_pkg::PI_F20;
            n_negp = 1'b1;
        end
    end

    logic signed [23:0] r_zt, r_zp;
    tcch_pkg::t_mag     r_mag [N+1];
    logic [N:0]         r_negt, r_negp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zt      <= n_zt;
            r_zp      <= n_zp;
            r_negt[0] <= n_negt;
            r_negp[0] <= n_negp;
            r_mag[0]  <= '{x: i_s_tdata[15:0], y: i_s_tdata[31:16], z: i_s_tdata[47:32]};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_mag[k+1]  <= r_mag[k];
                r_negt[k+1] <= r_negt[k];
                r_negp[k+1] <= r_negp[k];
            end
        end
    end

    logic signed [18:0] ct_raw, st_raw, cp_raw, sp_raw, ct, st, cp, sp;

    tcch_sincos #(.CORDIC_STEPS(N)) u_sc_t (
        .i_clk (i_clk), .i_en (en), .i_z (r_zt), .o_cos (ct_raw), .o_sin (st_raw)
    );
    tcch_sincos #(.CORDIC_STEPS(N)) u_sc_p (
        .i_clk (i_clk), .i_en (en), .i_z (r_zp), .o_cos (cp_raw), .o_sin (sp_raw)
    );

    assign ct = r_negt[N] ? -ct_raw : ct_raw;
    assign st = r_negt[N] ? -st_raw : st_raw;
    assign cp = r_negp[N] ? -cp_raw : cp_raw;
    assign sp = r_negp[N] ? -sp_raw : sp_raw;

    // rotation products
    logic signed [34:0] r_a, r_d, r_e;
    logic signed [37:0] r_b, r_c;
    logic signed [15:0] r_my1, r_mz1;
    logic signed [34:0] r_a2;
    logic signed [35:0] r_de;
    logic signed [53:0] r_bm, r_cm;
    logic signed [55:0] r_hx, r_hy;
    logic signed [55:0] r_vx, r_vy;
    logic signed [23:0] r_vz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a   <= r_mag[N].x * ct;
            r_b   <= st * sp;
            r_c   <= st * cp;
            r_d   <= r_mag[N].y * cp;
            r_e   <= r_mag[N].z * sp;
            r_my1 <= r_mag[N].y;
            r_mz1 <= r_mag[N].z;

            r_a2  <= r_a;
            r_de  <= 36'(r_d) - 36'(r_e);
            r_bm  <= r_b * r_my1;
            r_cm  <= r_c * r_mz1;

            r_hx  <= (56'(r_a2) <<< 16) + 56'(r_bm) + 56'(r_cm);
            r_hy  <= 56'(r_de) <<< 16;

            if (r_hy < 0) begin
                r_vx <= -r_hy;
                r_vy <= -r_hx;
                r_vz <= (r_hx >= 0) ? tcch_pkg::PI_F20 : -tcch_pkg::PI_F20;
            end else begin
                r_vx <= r_hy;
                r_vy <= r_hx;
                r_vz <= '0;
            end
        end
    end

    logic signed [23:0] a20;

    tcch_vector #(.CORDIC_STEPS(N)) u_vec (
        .i_clk (i_clk), .i_en (en), .i_x (r_vx), .i_y (r_vy), .i_z (r_vz), .o_z (a20)
    );

    // round to q3.13 and wrap into [0, 2*pi)
    logic signed [24:0] a_rnd;
    logic signed [19:0] a13, h0, n_h;
    logic [15:0]        r_h;

    assign a_rnd = 25'(a20) + 25'sd64;
    assign a13   = 20'(a_rnd >>> 7);
    assign h0    = tcch_pkg::PI_Q13 - a13;

    always_comb begin
        n_h = h0;
        if (h0 < 0) begin
            n_h = h0 + tcch_pkg::TWO_PI_Q13;
        end else if (h0 >= tcch_pkg::TWO_PI_Q13) begin
            n_h = h0 - tcch_pkg::TWO_PI_Q13;
        end
    end

    logic [32:0] deg_full;
    logic [16:0] deg;
    logic [15:0] n_out, r_out;

    assign deg_full = 33'(r_h) * 33'(tcch_pkg::DEG_MUL) + 33'd32768;
    assign deg      = deg_full[32:16];

    always_comb begin
        if (r_unit) begin
            n_out = (deg > tcch_pkg::DEG_MAX) ? tcch_pkg::DEG_MAX[15:0] : deg[15:0];
        end else begin
            n_out = r_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h   <= n_h[15:0];
            r_out <= n_out;
        end
    end

    assign o_m_tdata = r_out;

endmodule

>>> hdl/tcch_checker.sv
`include "tilt_compensated_compass_heading_defines.svh"

module tcch_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [79:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        i_cfg_we,
    input logic        i_cfg_wdata
);

    `TCCH_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid)
    `TCCH_ASSERT(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
    `TCCH_ASSERT(a_ready_when_drained, i_clk, i_rst_n, i_m_tready |-> o_s_tready)
    `TCCH_ASSERT(a_heading_range, i_clk, i_rst_n, o_m_tvalid |-> o_m_tdata < 16'd51472)
    `TCCH_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid)

endmodule

bind tilt_compensated_compass_heading tcch_checker u_tcch_checker (.*);

>>> tb/tb_tilt_compensated_compass_heading.sv
module tb_tilt_compensated_compass_heading;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 16;
    localparam int LATENCY = 2 * STEPS + 7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PI_F20_I = 3294199;
    localparam int HALF_PI_F20_I = 1647099;
    localparam int GAIN_I = 39797;
    localparam int PI_Q13_I = 25736;
    localparam int TWO_PI_Q13_I = 51472;
    localparam int DEG_MUL_I = 58671;
    localparam int DEG_MAX_I = 46079;
    localparam bit UNIT_RAD = 1'b0;
    localparam bit UNIT_DEG = 1'b1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [79:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;

    bit          unit_sel;
    logic [15:0] heading_q[$];
    int          errors;
    int          idle_cycles;
    bit          quiet;

    tilt_compensated_compass_heading #(.CORDIC_STEPS(STEPS)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic int atan_tab(int i);
        int t[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                      4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (i < 21) ? t[i] : 0;
    endfunction

    function automatic void rotate_sincos(input int a13, output int s, output int c);
        int z, x, y, dx, dy;
        bit flip;
        z = a13 * 128;
        flip = 1'b0;
        x = GAIN_I;
        y = 0;
        if (z > HALF_PI_F20_I) begin
            z -= PI_F20_I;
            flip = 1'b1;
        end else if (z < -HALF_PI_F20_I) begin
            z += PI_F20_I;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab(i);
            end else begin
                x += dx; y -= dy; z += atan_tab(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic int vector_angle(longint num, longint den);
        longint x, y, dx, dy;
        int z;
        x = den;
        y = num;
        z = 0;
        if (num == 0 && den == 0) return 0;
        if (den < 0) begin
            z = (num >= 0) ? PI_F20_I : -PI_F20_I;
            x = -den;
            y = -num;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_tab(i);
            end else if (y < 0) begin
                x -= dx; y += dy; z -= atan_tab(i);
            end
        end
        return z;
    endfunction

    function automatic logic [15:0] predict_heading(logic [79:0] d, bit deg);
        longint mx, my, mz, hx, hy, r;
        int st, ct, sp, cp, a13, h;
        mx = longint'($signed(d[15:0]));
        my = longint'($signed(d[31:16]));
        mz = longint'($signed(d[47:32]));
        rotate_sincos(-int'($signed(d[63:48])), st, ct);
        rotate_sincos(int'($signed(d[79:64])), sp, cp);
        hx = mx * ct * 65536 + my * st * sp + mz * st * cp;
        hy = (my * cp - mz * sp) * 65536;
        a13 = (vector_angle(hx, hy) + 64) >>> 7;
        h = PI_Q13_I - a13;
        if (h < 0) h += TWO_PI_Q13_I;
        if (h >= TWO_PI_Q13_I) h -= TWO_PI_Q13_I;
        if (deg) begin
            r = (longint'(h) * DEG_MUL_I + 32768) >>> 16;
            if (r > DEG_MAX_I) r = DEG_MAX_I;
        end else begin
            r = h;
        end
        return r[15:0];
    endfunction

    task automatic send_sample(input logic [15:0] mx, my, mz, pitch, roll);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tdata <= {roll, pitch, mz, my, mx};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        heading_q.push_back(predict_heading({roll, pitch, mz, my, mx}, unit_sel));
    endtask

    task automatic finish_requests();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (heading_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic set_unit(input bit u);
        finish_requests();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= u;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        unit_sel = u;
    endtask

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 51472) - 25736);
            1: return 16'($urandom_range(0, 13000) - 6500);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 4) - 2);
            1: return 16'($urandom_range(0, 2000) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] ext[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h1234};
        send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(16'd0, 16'd0, 16'd0, 16'd25736, 16'hb5f8);
        send_sample(16'd1000, 16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(16'd0, 16'd1000, 16'd0, 16'd0, 16'd0);
        send_sample(16'hfc18, 16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(16'd0, 16'hfc18, 16'd0, 16'd0, 16'd0);
        send_sample(16'hfc18, 16'hffff, 16'd0, 16'd0, 16'd0);
        send_sample(16'hfc18, 16'h0001, 16'd0, 16'd0, 16'd0);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'd300, 16'd200, 16'd500, 16'd12868, 16'hcdbc);
        send_sample(16'd300, 16'd200, 16'd500, 16'd13000, 16'hcd00);
        for (int i = 0; i < 6; i++) begin
            send_sample(ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6],
                        ext[(i + 3) % 6], ext[(i + 4) % 6]);
        end
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) begin
            send_sample(rand_field(), rand_field(), rand_field(), rand_angle(), rand_angle());
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (heading_q.size() == 0) begin
                $error("unexpected heading %0d", o_m_tdata);
                errors++;
            end else begin
                if (o_m_tdata !== heading_q[0]) begin
                    $error("heading expected %0d actual %0d", heading_q[0], o_m_tdata);
                    errors++;
                end
                void'(heading_q.pop_front());
            end
        end
    end

    // output stall in bursts
    int stall_left;
    always @(posedge i_clk) begin
        if (quiet) begin
            i_m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        unit_sel = UNIT_RAD;
        test_directed();
        set_unit(UNIT_DEG);
        test_directed();
        test_random(250);
        set_unit(UNIT_RAD);
        test_random(250);
        set_unit(UNIT_DEG);
        quiet = 1'b1;
        test_random(150);
        finish_requests();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
